// File: rtl/icfr_pkg.sv
package icfr_pkg;

    // Frame kind as carried in the header of the first byte.
    typedef logic [1:0] kind_t;

    localparam kind_t KIND_INIT = 2'd0;
    localparam kind_t KIND_CONT = 2'd1;

    // Status reported on the last byte of a frame.
    typedef logic [1:0] status_t;

    localparam status_t STATUS_WAITING  = 2'd0;
    localparam status_t STATUS_COMPLETE = 2'd1;
    localparam status_t STATUS_SEQ_ERR  = 2'd2;
    localparam status_t STATUS_UNKNOWN  = 2'd3;

    // Byte position within a frame saturates at the top of an 11-bit counter.
    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Bytes delivered by one frame; payload sizes are at most 1024.
    localparam int CHUNK_W = 11;

    // Message length, byte offsets and frame counts.
    localparam int LEN_W = 16;

endpackage

// File: rtl/init_cont_frame_reassembler.sv
// The result of a request is registered at the clock edge that accepts it.
// Throughput: one request per cycle; a request is taken while the result register
// is empty or being drained in the same cycle, so a stalled output holds one result.
// The per-byte path is a 17-bit sequence compare, a min/subtract and an offset add.
// Reset clears all frame and message state and the result register's valid flag.
module init_cont_frame_reassembler #(
    parameter int INIT_PAYLOAD_BYTES = 57,
    parameter int CONT_PAYLOAD_BYTES = 59
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_ready,
    input  icfr_pkg::kind_t     kind,
    input  logic [31:0]         channel_id,
    input  logic [15:0]         byte_count,
    input  logic [15:0]         seq_number,
    input  logic [7:0]          data_byte,
    input  logic                last_in_frame,

    output logic                result_valid,
    input  logic                result_ready,
    output logic                byte_valid,
    output logic [15:0]         byte_offset,
    output logic [7:0]          byte_value,
    output logic                frame_done,
    output icfr_pkg::status_t   status,
    output logic [31:0]         channel_out
);

    import icfr_pkg::*;

    // Payload sizes at the widths of the length and chunk paths.
    localparam logic [LEN_W-1:0]   INIT_LEN   = LEN_W'(INIT_PAYLOAD_BYTES);
    localparam logic [LEN_W-1:0]   CONT_LEN   = LEN_W'(CONT_PAYLOAD_BYTES);
    localparam logic [LEN_W:0]     CONT_ROUND = (LEN_W + 1)'(CONT_PAYLOAD_BYTES - 1);

    // Ceiling division by the continuation size as a reciprocal multiply.
    // The numerator has 17 bits; the shift covers it plus the divisor's log2.
    localparam int               NUM_W     = LEN_W + 1;
    localparam int               DIV_SHIFT = NUM_W + $clog2(CONT_PAYLOAD_BYTES);
    localparam int               MULT_W    = NUM_W + 2;
    localparam int               PROD_W    = NUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + 64'(CONT_PAYLOAD_BYTES) - 64'd1)
                / 64'(CONT_PAYLOAD_BYTES));

    // Message and frame state.
    logic [31:0]        current_channel_reg, current_channel_next;
    logic [LEN_W-1:0]   message_length_reg, message_length_next;
    logic [LEN_W-1:0]   bytes_so_far_reg, bytes_so_far_next;
    logic [LEN_W-1:0]   conts_expected_reg, conts_expected_next;
    logic [LEN_W-1:0]   conts_received_reg, conts_received_next;
    logic [POS_W-1:0]   pos_in_frame_reg, pos_in_frame_next;
    kind_t              frame_kind_held_reg, frame_kind_held_next;
    logic               frame_rejected_reg, frame_rejected_next;
    logic [CHUNK_W-1:0] frame_chunk_reg, frame_chunk_next;

    // Result register.
    logic               result_valid_reg;
    logic               byte_valid_reg, byte_valid_next;
    logic [15:0]        byte_offset_reg, byte_offset_next;
    logic [7:0]         byte_value_reg, byte_value_next;
    logic               frame_done_reg;
    status_t            status_reg, status_next;
    logic [31:0]        channel_out_reg;

    logic               accept;
    logic               first_byte;
    logic               seq_ok;
    logic [LEN_W-1:0]   init_chunk;
    logic [LEN_W-1:0]   remaining;
    logic [LEN_W-1:0]   cont_chunk;
    logic [LEN_W-1:0]   rest_len;
    logic [NUM_W-1:0]   div_num;
    logic [PROD_W-1:0]  div_prod;
    logic [LEN_W-1:0]   conts_for_len;
    logic [LEN_W-1:0]   received_inc;
    logic               in_chunk;

    // A request enters whenever the result register is free or drains now.
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;
    assign first_byte = (pos_in_frame_reg == '0);

    // Continuation frames due for the new length, rounded up.
    always_comb
    begin
        rest_len      = (byte_count > INIT_LEN) ? (byte_count - INIT_LEN) : '0;
        div_num       = {1'b0, rest_len} + CONT_ROUND;
        div_prod      = PROD_W'(div_num) * PROD_W'(DIV_MULT);
        conts_for_len = LEN_W'(div_prod >> DIV_SHIFT);
    end

    // Chunk sizes for an init frame and for an accepted continuation frame.
    always_comb
    begin
        init_chunk   = (byte_count < INIT_LEN) ? byte_count : INIT_LEN;
        remaining    = (message_length_reg > bytes_so_far_reg)
                       ? (message_length_reg - bytes_so_far_reg) : '0;
        cont_chunk   = (remaining < CONT_LEN) ? remaining : CONT_LEN;
        seq_ok       = ({1'b0, seq_number} == ({1'b0, conts_received_reg} + 17'd1));
        received_inc = conts_received_reg + 16'd1;
    end

    // Frame header handling on the first byte, then delivery and frame end.
    always_comb
    begin
        current_channel_next = current_channel_reg;
        message_length_next  = message_length_reg;
        bytes_so_far_next    = bytes_so_far_reg;
        conts_expected_next  = conts_expected_reg;
        conts_received_next  = conts_received_reg;
        frame_kind_held_next = frame_kind_held_reg;
        frame_rejected_next  = frame_rejected_reg;
        frame_chunk_next     = frame_chunk_reg;
        byte_valid_next      = 1'b0;
        byte_offset_next     = '0;
        byte_value_next      = '0;
        status_next          = STATUS_WAITING;

        // The first byte fixes the frame kind and samples the header.
        if (first_byte)
        begin
            frame_kind_held_next = kind;
            frame_rejected_next  = 1'b0;
            frame_chunk_next     = '0;
            if (kind == KIND_INIT)
            begin
                current_channel_next = channel_id;
                message_length_next  = byte_count;
                conts_expected_next  = conts_for_len;
                conts_received_next  = '0;
                bytes_so_far_next    = init_chunk;
                frame_chunk_next     = CHUNK_W'(init_chunk);
            end
            else if (kind == KIND_CONT)
            begin
                if (!seq_ok)
                begin
                    frame_rejected_next = 1'b1;
                end
                else
                begin
                    frame_chunk_next = CHUNK_W'(cont_chunk);
                end
            end
        end

        in_chunk = (pos_in_frame_reg < frame_chunk_next);

        // Deliver bytes that fall inside this frame's chunk.
        if (frame_kind_held_next == KIND_INIT)
        begin
            if (in_chunk)
            begin
                byte_valid_next  = 1'b1;
                byte_offset_next = LEN_W'(pos_in_frame_reg);
                byte_value_next  = data_byte;
            end
        end
        else if ((frame_kind_held_next == KIND_CONT) && !frame_rejected_next)
        begin
            if (in_chunk)
            begin
                byte_valid_next  = 1'b1;
                byte_offset_next = bytes_so_far_next + LEN_W'(pos_in_frame_reg);
                byte_value_next  = data_byte;
            end
        end

        // Frame end: report the status; an accepted continuation also advances the counts.
        if (last_in_frame)
        begin
            priority if (frame_kind_held_next == KIND_INIT)
            begin
                status_next = (conts_expected_next == conts_received_next)
                              ? STATUS_COMPLETE : STATUS_WAITING;
            end
            else if (frame_kind_held_next == KIND_CONT)
            begin
                if (frame_rejected_next)
                begin
                    status_next = STATUS_SEQ_ERR;
                end
                else
                begin
                    bytes_so_far_next   = bytes_so_far_next + LEN_W'(frame_chunk_next);
                    conts_received_next = received_inc;
                    status_next = (conts_expected_next == received_inc)
                                  ? STATUS_COMPLETE : STATUS_WAITING;
                end
            end
            else
            begin
                status_next = STATUS_UNKNOWN;
            end
            pos_in_frame_next = '0;
        end
        else
        begin
            pos_in_frame_next = (pos_in_frame_reg == POS_MAX)
                                ? POS_MAX : (pos_in_frame_reg + 1'b1);
        end
    end

    // State registers advance on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_channel_reg <= '0;
            message_length_reg  <= '0;
            bytes_so_far_reg    <= '0;
            conts_expected_reg  <= '0;
            conts_received_reg  <= '0;
            pos_in_frame_reg    <= '0;
            frame_kind_held_reg <= KIND_INIT;
            frame_rejected_reg  <= 1'b0;
            frame_chunk_reg     <= '0;
        end
        else if (accept)
        begin
            current_channel_reg <= current_channel_next;
            message_length_reg  <= message_length_next;
            bytes_so_far_reg    <= bytes_so_far_next;
            conts_expected_reg  <= conts_expected_next;
            conts_received_reg  <= conts_received_next;
            pos_in_frame_reg    <= pos_in_frame_next;
            frame_kind_held_reg <= frame_kind_held_next;
            frame_rejected_reg  <= frame_rejected_next;
            frame_chunk_reg     <= frame_chunk_next;
        end
    end

    // Result valid flag: set on accept, cleared when the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_valid_reg  <= byte_valid_next;
            byte_offset_reg <= byte_offset_next;
            byte_value_reg  <= byte_value_next;
            frame_done_reg  <= last_in_frame;
            status_reg      <= status_next;
            channel_out_reg <= current_channel_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign byte_valid   = byte_valid_reg;
    assign byte_offset  = byte_offset_reg;
    assign byte_value   = byte_value_reg;
    assign frame_done   = frame_done_reg;
    assign status       = status_reg;
    assign channel_out  = channel_out_reg;

endmodule

// File: sim/testbench.sv
module testbench;

    import icfr_pkg::*;

    localparam int INIT_BYTES      = 57;
    localparam int CONT_BYTES      = 59;
    localparam int STALL_LIMIT     = 1000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int PHASE_REQUESTS  = 275;
    localparam int SATURATE_BYTES  = 2060;

    // Frame kinds that the block does not know; it reports them at frame end.
    localparam kind_t KIND_RSVD_A = 2'd2;
    localparam kind_t KIND_RSVD_B = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] channel_id;
        logic [15:0] byte_count;
        logic [15:0] seq_number;
        logic [7:0]  data_byte;
        logic        last_in_frame;
    } request_t;

    typedef struct packed {
        logic        byte_valid;
        logic [15:0] byte_offset;
        logic [7:0]  byte_value;
        logic        frame_done;
        status_t     status;
        logic [31:0] channel;
    } delivery_t;

    // Tracks the message being reassembled and holds the deliveries still owed.
    class reassembly_scoreboard;
        logic [31:0] msg_channel;
        logic [15:0] msg_length;
        logic [15:0] msg_bytes_done;
        logic [15:0] conts_due;
        logic [15:0] conts_seen;
        logic [10:0] frame_pos;
        kind_t       frame_kind;
        bit          frame_dropped;
        logic [10:0] frame_take;
        delivery_t   expected_deliveries[$];
        int          mismatches;

        function new();
            msg_channel    = '0;
            msg_length     = '0;
            msg_bytes_done = '0;
            conts_due      = '0;
            conts_seen     = '0;
            frame_pos      = '0;
            frame_kind     = KIND_INIT;
            frame_dropped  = 1'b0;
            frame_take     = '0;
            mismatches     = 0;
        endfunction

        // Works out what one accepted request must deliver and queues it.
        function void note_request(input request_t req);
            delivery_t want;
            int        remaining;
            want = '0;

            // The header is sampled on the first byte of each frame only.
            if (frame_pos == '0)
            begin
                frame_kind    = req.kind;
                frame_dropped = 1'b0;
                frame_take    = '0;
                if (req.kind == KIND_INIT)
                begin
                    msg_channel = req.channel_id;
                    msg_length  = req.byte_count;
                    if (int'(req.byte_count) <= INIT_BYTES)
                        conts_due = '0;
                    else
                        conts_due = 16'((int'(req.byte_count) - INIT_BYTES + CONT_BYTES - 1)
                                        / CONT_BYTES);
                    conts_seen     = '0;
                    msg_bytes_done = (int'(req.byte_count) < INIT_BYTES) ?
                                     req.byte_count : 16'(INIT_BYTES);
                    frame_take     = 11'(msg_bytes_done);
                end
                else if (req.kind == KIND_CONT)
                begin
                    if (int'(req.seq_number) != int'(conts_seen) + 1)
                        frame_dropped = 1'b1;
                    else
                    begin
                        remaining  = (msg_length > msg_bytes_done) ?
                                     int'(msg_length - msg_bytes_done) : 0;
                        frame_take = 11'((remaining < CONT_BYTES) ? remaining : CONT_BYTES);
                    end
                end
            end

            // Bytes inside the chunk of an init or accepted continuation frame go out.
            if (frame_pos < frame_take &&
                (frame_kind == KIND_INIT || (frame_kind == KIND_CONT && !frame_dropped)))
            begin
                want.byte_valid  = 1'b1;
                want.byte_value  = req.data_byte;
                want.byte_offset = (frame_kind == KIND_INIT) ?
                                   16'(frame_pos) : msg_bytes_done + 16'(frame_pos);
            end

            // The last byte of a frame carries the status; an accepted continuation advances the counts.
            if (req.last_in_frame)
            begin
                want.frame_done = 1'b1;
                if (frame_kind == KIND_INIT)
                    want.status = (conts_due == conts_seen) ? STATUS_COMPLETE : STATUS_WAITING;
                else if (frame_kind == KIND_CONT && frame_dropped)
                    want.status = STATUS_SEQ_ERR;
                else if (frame_kind == KIND_CONT)
                begin
                    msg_bytes_done = msg_bytes_done + 16'(frame_take);
                    conts_seen     = conts_seen + 16'd1;
                    want.status    = (conts_due == conts_seen) ? STATUS_COMPLETE : STATUS_WAITING;
                end
                else
                    want.status = STATUS_UNKNOWN;
                frame_pos = '0;
            end
            else if (frame_pos != POS_MAX)
                frame_pos = frame_pos + 11'd1;

            want.channel = msg_channel;
            expected_deliveries.push_back(want);
        endfunction

        task report(input string what);
            $display("ERROR at %0t: %s", $time, what);
            mismatches++;
        endtask

        // Compares one accepted result with the oldest delivery owed.
        task check_result(input delivery_t got);
            delivery_t want;
            if (expected_deliveries.size() == 0)
            begin
                report("result arrived with no request outstanding");
                return;
            end
            want = expected_deliveries.pop_front();
            if (got.byte_valid !== want.byte_valid)
                report($sformatf("byte_valid is %0h, expected %0h",
                                 got.byte_valid, want.byte_valid));
            if (got.byte_offset !== want.byte_offset)
                report($sformatf("byte_offset is %0h, expected %0h",
                                 got.byte_offset, want.byte_offset));
            if (got.byte_value !== want.byte_value)
                report($sformatf("byte_value is %0h, expected %0h",
                                 got.byte_value, want.byte_value));
            if (got.frame_done !== want.frame_done)
                report($sformatf("frame_done is %0h, expected %0h",
                                 got.frame_done, want.frame_done));
            if (got.status !== want.status)
                report($sformatf("status is %0h, expected %0h", got.status, want.status));
            if (got.channel !== want.channel)
                report($sformatf("channel_out is %0h, expected %0h", got.channel, want.channel));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    kind_t       kind;
    logic [31:0] channel_id;
    logic [15:0] byte_count;
    logic [15:0] seq_number;
    logic [7:0]  data_byte;
    logic        last_in_frame;
    logic        result_valid;
    logic        result_ready;
    logic        byte_valid;
    logic [15:0] byte_offset;
    logic [7:0]  byte_value;
    logic        frame_done;
    status_t     status;
    logic [31:0] channel_out;

    reassembly_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_requests;
    int hold_off_served;
    int hold_off_left;
    int requests_sent;
    int stall_cycles;

    init_cont_frame_reassembler #(
        .INIT_PAYLOAD_BYTES (INIT_BYTES),
        .CONT_PAYLOAD_BYTES (CONT_BYTES)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .kind          (kind),
        .channel_id    (channel_id),
        .byte_count    (byte_count),
        .seq_number    (seq_number),
        .data_byte     (data_byte),
        .last_in_frame (last_in_frame),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .byte_valid    (byte_valid),
        .byte_offset   (byte_offset),
        .byte_value    (byte_value),
        .frame_done    (frame_done),
        .status        (status),
        .channel_out   (channel_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offers one request, with random idle cycles ahead of it, until it is taken.
    task automatic send_request(input request_t req);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid    <= 1'b1;
        kind          <= req.kind;
        channel_id    <= req.channel_id;
        byte_count    <= req.byte_count;
        seq_number    <= req.seq_number;
        data_byte     <= req.data_byte;
        last_in_frame <= req.last_in_frame;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_request(req);
        requests_sent++;
        @(negedge clk);
    endtask

    // Sends one frame; header fields on bytes after the first are random noise.
    task automatic send_frame(input kind_t k, input logic [31:0] chan,
                              input logic [15:0] count, input logic [15:0] seq,
                              input int nbytes);
        request_t req;
        for (int i = 0; i < nbytes; i++)
        begin
            req.kind       = kind_t'($urandom);
            req.channel_id = $urandom;
            req.byte_count = 16'($urandom);
            req.seq_number = 16'($urandom);
            req.data_byte  = 8'($urandom);
            if (i == 0)
            begin
                req.kind       = k;
                req.channel_id = chan;
                req.byte_count = count;
                req.seq_number = seq;
            end
            req.last_in_frame = (i == nbytes - 1);
            send_request(req);
        end
    endtask

    // Sends one message: an init frame and its continuation frames, with some
    // short or long frames, bad sequence numbers, surplus frames and unknown kinds.
    task automatic send_message();
        logic [15:0] len;
        logic [15:0] bad_seq;
        int          pick;
        int          nbytes;
        int          conts_to_send;
        int          next_seq;
        int          left;
        pick = $urandom_range(99);
        if (pick < 40)
            len = 16'($urandom_range(INIT_BYTES, 0));
        else if (pick < 85)
            len = 16'($urandom_range(400, INIT_BYTES + 1));
        else if (pick < 95)
            len = 16'($urandom_range(2000, 401));
        else
            len = 16'($urandom);

        nbytes = (int'(len) < INIT_BYTES) ? int'(len) : INIT_BYTES;
        if (nbytes == 0)
            nbytes = 1;
        if ($urandom_range(99) < 15)
            nbytes = $urandom_range(70, 1);
        send_frame(KIND_INIT, $urandom, len, 16'($urandom), nbytes);

        conts_to_send = (int'(len) > INIT_BYTES) ?
                        (int'(len) - INIT_BYTES + CONT_BYTES - 1) / CONT_BYTES : 0;
        if (conts_to_send > 8)
            conts_to_send = 8;
        pick = $urandom_range(99);
        if (pick < 10)
            conts_to_send = conts_to_send + $urandom_range(2, 1);
        else if (pick < 20 && conts_to_send > 0)
            conts_to_send = conts_to_send - 1;

        left     = (int'(len) > INIT_BYTES) ? int'(len) - INIT_BYTES : 0;
        next_seq = 1;
        while (next_seq <= conts_to_send)
        begin
            if ($urandom_range(99) < 5)
                send_frame(($urandom_range(1) != 0) ? KIND_RSVD_A : KIND_RSVD_B,
                           $urandom, 16'($urandom), 16'($urandom), $urandom_range(5, 1));
            nbytes = (left < CONT_BYTES) ? left : CONT_BYTES;
            if (nbytes == 0)
                nbytes = 1;
            if ($urandom_range(99) < 15)
                nbytes = $urandom_range(70, 1);
            if ($urandom_range(99) < 10)
            begin
                bad_seq = 16'($urandom);
                if (int'(bad_seq) == next_seq)
                    bad_seq = bad_seq + 16'd1;
                send_frame(KIND_CONT, $urandom, 16'($urandom), bad_seq, nbytes);
            end
            else
            begin
                send_frame(KIND_CONT, $urandom, 16'($urandom), 16'(next_seq), nbytes);
                left = (left > CONT_BYTES) ? left - CONT_BYTES : 0;
                next_seq++;
            end
        end
    endtask

    // Receiver side: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off_requests != hold_off_served)
        begin
            hold_off_served = hold_off_requests;
            hold_off_left   = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Every accepted result is checked against the oldest delivery owed.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(delivery_t'{byte_valid, byte_offset, byte_value,
                                        frame_done, status, channel_out});
    end

    // Ends the run when neither channel has moved for too long.
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        request_t req;
        sb                 = new();
        rst_n              = 1'b0;
        item_valid         = 1'b0;
        kind               = KIND_INIT;
        channel_id         = '0;
        byte_count         = '0;
        seq_number         = '0;
        data_byte          = '0;
        last_in_frame      = 1'b0;
        result_ready       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_requests  = 0;
        hold_off_served    = 0;
        hold_off_left      = 0;
        requests_sent      = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A continuation before any init runs against the reset state.
        send_frame(KIND_CONT, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 1);
        // Unknown kinds deliver nothing and report so at frame end.
        send_frame(KIND_RSVD_A, 32'h0, 16'h0, 16'h0, 1);
        send_frame(KIND_RSVD_B, 32'h1234_5678, 16'h0, 16'hFFFF, 2);
        // An empty message completes on its init frame.
        send_frame(KIND_INIT, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 1);
        // A short complete message with extreme data bytes.
        req = '{KIND_INIT, 32'hA5A5_5A5A, 16'd3, 16'd0, 8'h00, 1'b0};
        send_request(req);
        req = '{KIND_CONT, 32'h0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0};
        send_request(req);
        req = '{KIND_RSVD_B, 32'hFFFF_FFFF, 16'h0, 16'h0, 8'h5A, 1'b1};
        send_request(req);
        // Short init frame, two wrong sequences, the right one, then a surplus frame.
        send_frame(KIND_INIT, 32'h0000_0001, 16'd60, 16'd0, 2);
        send_frame(KIND_CONT, 32'h0, 16'h0, 16'd2, 1);
        send_frame(KIND_CONT, 32'h0, 16'h0, 16'hFFFF, 1);
        send_frame(KIND_CONT, 32'h0, 16'h0, 16'd1, 2);
        send_frame(KIND_CONT, 32'h0, 16'h0, 16'd2, 1);
        // The longest message, opened by a short init frame.
        send_frame(KIND_INIT, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 1);
        send_frame(KIND_CONT, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 2);
        send_frame(KIND_CONT, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 1);

        // Random messages under each idling pattern.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 49;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 49;
                end
                default:
                begin
                    sender_idle_pct    = 14;
                    receiver_stall_pct = 14;
                end
            endcase
            // The receiver holds off for a long stretch while requests keep coming.
            if (phase == 2)
                hold_off_requests++;
            // A frame far longer than any payload drives the byte index into saturation.
            if (phase == 0)
                send_frame(KIND_INIT, $urandom, 16'd57, 16'($urandom), SATURATE_BYTES);
            while (requests_sent < (phase + 1) * PHASE_REQUESTS + SATURATE_BYTES)
                send_message();
        end
        item_valid <= 1'b0;

        while (sb.expected_deliveries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
